// ===== sv/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg: shared constants and the error function of the pileup counter
// Opcodes, CIGAR kinds, base codes, register indices and the error table.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

    localparam int REGION_DEPTH_DEF = 4096;
    localparam int BASES_PER_POSITION = 4;

    localparam logic [2:0] OP_HEADER = 3'd0;
    localparam logic [2:0] OP_CIGAR  = 3'd1;
    localparam logic [2:0] OP_BASE   = 3'd2;
    localparam logic [2:0] OP_QUERY  = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [3:0] CIG_M  = 4'd0;
    localparam logic [3:0] CIG_I  = 4'd1;
    localparam logic [3:0] CIG_D  = 4'd2;
    localparam logic [3:0] CIG_N  = 4'd3;
    localparam logic [3:0] CIG_S  = 4'd4;
    localparam logic [3:0] CIG_H  = 4'd5;
    localparam logic [3:0] CIG_EQ = 4'd7;
    localparam logic [3:0] CIG_X  = 4'd8;

    localparam logic [3:0] NT_A = 4'd1;
    localparam logic [3:0] NT_C = 4'd2;
    localparam logic [3:0] NT_G = 4'd4;
    localparam logic [3:0] NT_T = 4'd8;

    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;
    localparam logic [1:0] REG_MAPQ  = 2'd2;
    localparam logic [1:0] REG_BASEQ = 2'd3;

    localparam logic [11:0] REJECT_FLAGS = 12'h704;
    localparam logic [39:0] DEPTH_MAX = 40'hFF_FFFF_FFFF;

    // Error term round(10^-k * 2^40), k = quality div 10 capped at 9.
    function automatic logic [40:0] err_term(input logic [7:0] qual);
        logic [40:0] t;
        begin
            if (qual < 8'd10)       t = 41'd1099511627776;
            else if (qual < 8'd20)  t = 41'd109951162778;
            else if (qual < 8'd30)  t = 41'd10995116278;
            else if (qual < 8'd40)  t = 41'd1099511628;
            else if (qual < 8'd50)  t = 41'd109951163;
            else if (qual < 8'd60)  t = 41'd10995116;
            else if (qual < 8'd70)  t = 41'd1099512;
            else if (qual < 8'd80)  t = 41'd109951;
            else if (qual < 8'd90)  t = 41'd10995;
            else                    t = 41'd1100;
            return t;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/arpc_ram.sv =====
// ----------------------------------------------------------------------------
// arpc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/aligned_read_pileup_counter_unit.sv =====
// ----------------------------------------------------------------------------
// aligned_read_pileup_counter_unit: pileup base counter
// Header, CIGAR and base requests build per-position A/C/G/T counts.
// ----------------------------------------------------------------------------
// One request per cycle, back to back. Each row of the counter RAM holds the
// four 32-bit counters of one position; a base's row is read as the request is
// accepted and written back in the cycle after, with the row just written
// forwarded to a following request on the same row. A query's result passes
// through the stage 1 register and the output register. Apart from the clearing
// pass, the input stalls only while a query waits behind a result that has not
// been taken. After reset the block clears the counter RAM one row per cycle
// and accepts no request meanwhile; configuration writes are taken.
`default_nettype none

module aligned_read_pileup_counter_unit
    import arpc_pkg::*;
#(
    parameter int REGION_DEPTH = REGION_DEPTH_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [30:0]  i_cfg_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[2:0]
    input  wire  [2:0]   s_axis_tuser,
    // ref_position[30:0], mapping_quality[38:31], read_flags[50:39],
    // cigar_kind[54:51], cigar_length[82:55], base_code[86:83],
    // base_quality[94:87], zero fill to 96 bits
    input  wire  [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // count_a[31:0], count_c[63:32], count_g[95:64], count_t[127:96],
    // error_sum[191:128], depth_total[231:192], in_region[232], zero fill to 240
    output logic [239:0] m_axis_tdata
);

    localparam int AW = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1;
    localparam int RD = (REGION_DEPTH > 1) ? REGION_DEPTH : 2;
    localparam int RW = 32 * BASES_PER_POSITION;

    // ---------------- configuration
    logic [30:0] r_start, r_end;
    logic [7:0]  r_minmq, r_minbq;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0; r_end <= 31'd4095; r_minmq <= '0; r_minbq <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START: r_start <= i_cfg_data;
                REG_END:   r_end   <= i_cfg_data;
                REG_MAPQ:  r_minmq <= i_cfg_data[7:0];
                REG_BASEQ: r_minbq <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---------------- input fields
    logic [2:0]  in_op;
    logic [30:0] in_pos;
    logic [7:0]  in_mq, in_bq;
    logic [11:0] in_flags;
    logic [3:0]  in_kind, in_code;
    logic [27:0] in_len;
    assign in_op    = s_axis_tuser;
    assign in_pos   = s_axis_tdata[30:0];
    assign in_mq    = s_axis_tdata[38:31];
    assign in_flags = s_axis_tdata[50:39];
    assign in_kind  = s_axis_tdata[54:51];
    assign in_len   = s_axis_tdata[82:55];
    assign in_code  = s_axis_tdata[86:83];
    assign in_bq    = s_axis_tdata[94:87];

    // ---------------- clearing pass after reset
    logic        r_clr_busy;
    logic [AW:0] r_clr_cnt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1; r_clr_cnt <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == (AW+1)'(RD - 1)) r_clr_busy <= 1'b0;
        end
    end

    // ---------------- stage 0: read walker, row lookup
    logic [30:0] r_rstart;
    logic [31:0] r_roff;
    logic [3:0]  r_cop;
    logic [27:0] r_orem;
    logic        r_racc;

    logic        s2_full;
    logic        stall;
    logic        acc;
    assign s_axis_tready = !r_clr_busy && !stall;
    assign acc = s_axis_tvalid && s_axis_tready;

    logic [32:0] base_pos;
    logic        aligned_base;
    assign base_pos = {2'b0, r_rstart} + {1'b0, r_roff};
    assign aligned_base = (in_op == OP_BASE) && r_racc && (r_orem != '0) &&
                          (r_cop == CIG_M || r_cop == CIG_EQ || r_cop == CIG_X);

    logic [32:0] look_pos;
    assign look_pos = (in_op == OP_BASE) ? base_pos : {2'b0, in_pos};

    logic [32:0] rel;
    logic        hit;
    assign rel = look_pos - {2'b0, r_start};
    assign hit = (look_pos >= {2'b0, r_start}) && (look_pos <= {2'b0, r_end}) &&
                 (rel < 33'(REGION_DEPTH));

    logic [32:0] roff_sum;
    assign roff_sum = {1'b0, r_roff} + {5'b0, in_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rstart <= '0; r_roff <= '0; r_cop <= '0; r_orem <= '0; r_racc <= 1'b0;
        end else if (acc) begin
            case (in_op)
                OP_HEADER: begin
                    r_rstart <= in_pos; r_roff <= '0; r_cop <= '0; r_orem <= '0;
                    r_racc <= (in_mq >= r_minmq) && ((in_flags & REJECT_FLAGS) == '0);
                end
                OP_CIGAR: if (r_racc) begin
                    r_cop  <= in_kind;
                    r_orem <= '0;
                    if (in_kind == CIG_D || in_kind == CIG_N) begin
                        r_roff <= roff_sum[32] ? 32'hFFFF_FFFF : roff_sum[31:0];
                    end else if (in_kind == CIG_M || in_kind == CIG_EQ ||
                                 in_kind == CIG_X || in_kind == CIG_I ||
                                 in_kind == CIG_S) begin
                        r_orem <= in_len;
                    end
                end
                OP_BASE: if (r_racc && r_orem != '0) begin
                    r_orem <= r_orem - 1'b1;
                    if (aligned_base && r_roff != 32'hFFFF_FFFF) r_roff <= r_roff + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // ---------------- stage 1 register
    logic          r1_cnt, r1_clr, r1_qry, r1_hit;
    logic [AW-1:0] r1_row;
    logic [1:0]    r1_lane;
    logic          r1_lane_v;
    logic [40:0]   r1_err;

    logic [1:0] lane;
    logic       lane_v;
    always_comb begin
        lane = 2'd0; lane_v = 1'b1;
        case (in_code)
            NT_A: lane = 2'd0;
            NT_C: lane = 2'd1;
            NT_G: lane = 2'd2;
            NT_T: lane = 2'd3;
            default: lane_v = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_cnt <= 1'b0; r1_clr <= 1'b0; r1_qry <= 1'b0;
        end else if (!stall) begin
            r1_cnt <= acc && aligned_base && hit && (in_bq >= r_minbq);
            r1_clr <= acc && (in_op == OP_CLEAR);
            r1_qry <= acc && (in_op == OP_QUERY);
        end
    end
    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r1_hit <= hit; r1_row <= rel[AW-1:0]; r1_lane <= lane;
            r1_lane_v <= lane_v; r1_err <= err_term(in_bq);
        end
    end

    // ---------------- counter RAM
    logic [RW-1:0] ram_q, wr_row;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    arpc_ram #(.WIDTH(RW), .DEPTH(RD)) u_ram (
        .i_clk(i_clk), .i_we(wr_en), .i_waddr(wr_addr), .i_wdata(wr_row),
        .i_raddr(stall ? r1_row : rel[AW-1:0]), .o_rdata(ram_q)
    );

    // ---------------- stage 2: modify, write back, totals, result
    logic          r2_wr;
    logic [AW-1:0] r2_row;
    logic [RW-1:0] r2_data;

    // Forward the row just written when stage 1 reads the same row.
    logic [RW-1:0] cur_row, mod_row;
    assign cur_row = (r2_wr && r2_row == r1_row) ? r2_data : ram_q;

    always_comb begin
        mod_row = cur_row;
        if (r1_clr) begin
            mod_row = '0;
        end else if (r1_lane_v && cur_row[32*r1_lane +: 32] != 32'hFFFF_FFFF) begin
            mod_row[32*r1_lane +: 32] = cur_row[32*r1_lane +: 32] + 32'd1;
        end
    end

    logic s1_wr;
    assign s1_wr = !stall && ((r1_cnt && r1_lane_v) || (r1_clr && r1_hit));
    assign wr_en   = r_clr_busy || s1_wr;
    assign wr_addr = r_clr_busy ? r_clr_cnt[AW-1:0] : r1_row;
    assign wr_row  = r_clr_busy ? '0 : mod_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_wr <= 1'b0;
        end else begin
            r2_wr <= s1_wr;
        end
    end
    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            r2_row <= r1_row; r2_data <= mod_row;
        end
    end

    logic [63:0] r_err;
    logic [39:0] r_depth;
    logic [64:0] err_sum;
    assign err_sum = {1'b0, r_err} + {24'b0, r1_err};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= '0; r_depth <= '0;
        end else if (!stall) begin
            if (r1_clr) begin
                r_err <= '0; r_depth <= '0;
            end else if (r1_cnt) begin
                r_err <= err_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : err_sum[63:0];
                if (r_depth != DEPTH_MAX) r_depth <= r_depth + 1'b1;
            end
        end
    end

    // Output register; stage 1 stalls only while it holds a query behind a waiting result.
    assign s2_full = m_axis_tvalid && !m_axis_tready;
    assign stall   = s2_full && r1_qry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (!s2_full) begin
            m_axis_tvalid <= r1_qry;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!s2_full && r1_qry) begin
            m_axis_tdata <= {7'b0, r1_hit, r_depth, r_err,
                             r1_hit ? cur_row : {RW{1'b0}}};
        end
    end

`ifndef SYNTHESIS
    a_no_acc_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s_axis_tready) else $error("request taken while clearing");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> r1_qry) else $error("query lost during stall");
    a_no_wr_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |-> !s1_wr) else $error("write during stall");
`endif

endmodule

`default_nettype wire

// ===== sim/pileup_checker.sv =====
// ----------------------------------------------------------------------------
// pileup_checker: result predictor and comparator for the pileup counter
// Watches the request and result streams and the configuration port, keeps
// its own copy of the counters and totals, and compares every query result.
// ----------------------------------------------------------------------------
`default_nettype none

module pileup_checker
    import arpc_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [30:0]  i_cfg_data,
    input  wire          i_req_valid,
    input  wire          i_req_ready,
    input  wire  [2:0]   i_req_user,
    input  wire  [95:0]  i_req_data,
    input  wire          i_res_valid,
    input  wire          i_res_ready,
    input  wire  [239:0] i_res_data,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_queries_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        in_region;
        logic [39:0] depth_total;
        logic [63:0] error_sum;
        logic [31:0] count_t;
        logic [31:0] count_g;
        logic [31:0] count_c;
        logic [31:0] count_a;
    } t_pileup_result;

    logic [31:0] counts [0:REGION_DEPTH_DEF*4-1];
    logic [63:0] err_acc;
    logic [39:0] depth_acc;
    logic [30:0] walk_start;
    logic [31:0] offset;
    logic [3:0]  active_op;
    logic [27:0] op_left;
    logic        read_ok;
    logic [30:0] win_start, win_end;
    logic [7:0]  mapq_floor, baseq_floor;
    t_pileup_result expected_results[$];

    function automatic logic [63:0] error_step(input logic [7:0] q);
        logic [63:0] tbl [0:9];
        int k;
        tbl = '{64'd1099511627776, 64'd109951162778, 64'd10995116278,
                64'd1099511628, 64'd109951163, 64'd10995116, 64'd1099512,
                64'd109951, 64'd10995, 64'd1100};
        k = q / 10;
        if (k > 9) k = 9;
        return tbl[k];
    endfunction

    function automatic bit row_of(input logic [32:0] p, output int row);
        row = 0;
        if (p < win_start || p > win_end) return 0;
        if (p - win_start >= REGION_DEPTH_DEF) return 0;
        row = int'(p - win_start);
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    task automatic tally_base(input logic [3:0] code, input logic [7:0] qual);
        logic [32:0] p;
        int row, lane;
        logic [64:0] sum;
        p = {2'b0, walk_start} + {1'b0, offset};
        if (offset != 32'hFFFF_FFFF) offset++;
        if (!row_of(p, row)) return;
        if (qual < baseq_floor) return;
        sum = {1'b0, err_acc} + {1'b0, error_step(qual)};
        err_acc = sum[64] ? '1 : sum[63:0];
        if (depth_acc != DEPTH_MAX) depth_acc++;
        case (code)
            NT_A: lane = 0;
            NT_C: lane = 1;
            NT_G: lane = 2;
            NT_T: lane = 3;
            default: lane = -1;
        endcase
        if (lane >= 0 && counts[row*4+lane] != 32'hFFFF_FFFF)
            counts[row*4+lane]++;
    endtask

    task automatic predict(input logic [2:0] opc, input logic [95:0] d);
        logic [30:0] pos;
        logic [3:0]  kind;
        logic [27:0] len;
        logic [32:0] off;
        t_pileup_result r;
        int row;
        bit hit;
        pos = d[30:0];
        kind = d[54:51];
        len = d[82:55];
        case (opc)
            OP_HEADER: begin
                walk_start = pos;
                offset = 0;
                active_op = CIG_M;
                op_left = 0;
                read_ok = (d[38:31] >= mapq_floor) && ((d[50:39] & REJECT_FLAGS) == 0);
            end
            OP_CIGAR: if (read_ok) begin
                active_op = kind;
                op_left = 0;
                if (kind == CIG_D || kind == CIG_N) begin
                    off = {1'b0, offset} + {5'b0, len};
                    offset = off[32] ? 32'hFFFF_FFFF : off[31:0];
                end else if (kind inside {CIG_M, CIG_EQ, CIG_X, CIG_I, CIG_S}) begin
                    op_left = len;
                end
            end
            OP_BASE: if (read_ok && op_left != 0) begin
                op_left--;
                if (active_op inside {CIG_M, CIG_EQ, CIG_X})
                    tally_base(d[86:83], d[94:87]);
            end
            OP_QUERY: begin
                hit = row_of({2'b0, pos}, row);
                r.count_a = hit ? counts[row*4]   : 0;
                r.count_c = hit ? counts[row*4+1] : 0;
                r.count_g = hit ? counts[row*4+2] : 0;
                r.count_t = hit ? counts[row*4+3] : 0;
                r.error_sum = err_acc;
                r.depth_total = depth_acc;
                r.in_region = hit;
                expected_results.push_back(r);
            end
            OP_CLEAR: begin
                if (row_of({2'b0, pos}, row))
                    for (int j = 0; j < 4; j++) counts[row*4+j] = 0;
                err_acc = 0;
                depth_acc = 0;
            end
            default: ;
        endcase
    endtask

    task automatic compare_result(input logic [239:0] d);
        t_pileup_result got, want;
        got = d[232:0];
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", d[63:0], 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.count_a !== want.count_a) report_mismatch("count_a", got.count_a, want.count_a);
        if (got.count_c !== want.count_c) report_mismatch("count_c", got.count_c, want.count_c);
        if (got.count_g !== want.count_g) report_mismatch("count_g", got.count_g, want.count_g);
        if (got.count_t !== want.count_t) report_mismatch("count_t", got.count_t, want.count_t);
        if (got.error_sum !== want.error_sum)
            report_mismatch("error_sum", got.error_sum, want.error_sum);
        if (got.depth_total !== want.depth_total)
            report_mismatch("depth_total", got.depth_total, want.depth_total);
        if (got.in_region !== want.in_region)
            report_mismatch("in_region", got.in_region, want.in_region);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REGION_DEPTH_DEF*4; i++) counts[i] = 0;
            err_acc = 0;
            depth_acc = 0;
            walk_start = 0;
            offset = 0;
            active_op = CIG_M;
            op_left = 0;
            read_ok = 0;
            win_start = 0;
            win_end = 31'd4095;
            mapq_floor = 0;
            baseq_floor = 0;
            expected_results.delete();
            o_fail_count = 0;
            o_queries_seen = 0;
        end else begin
            // Results come out after acceptance, so check first, then predict.
            if (i_res_valid && i_res_ready) begin
                compare_result(i_res_data);
                o_queries_seen++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_START: win_start = i_cfg_data;
                    REG_END:   win_end = i_cfg_data;
                    REG_MAPQ:  mapq_floor = i_cfg_data[7:0];
                    REG_BASEQ: baseq_floor = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) predict(i_req_user, i_req_data);
        end
        o_pending = expected_results.size();
    end
endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the pileup counter
// Drives reads, CIGAR ops, bases, queries and clears over several region and
// quality settings and idling phases; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import arpc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_index;
    logic [30:0]   i_cfg_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [2:0]    s_axis_tuser;
    logic [95:0]   s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [239:0]  m_axis_tdata;
    int            fail_count;
    int            pending;
    int            queries_seen;
    int            send_idle_pct;
    int            stall_pct;
    int            items_sent;
    logic [30:0]   win_lo;

    aligned_read_pileup_counter_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    pileup_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_user(s_axis_tuser), .i_req_data(s_axis_tdata),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_queries_seen(queries_seen)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Timeout");
        $display("Verification failed");
        $finish;
    end

    // Receiver stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Returns the opcode in the low three bits with the data fields above it.
    function automatic logic [98:0] pack_request(
        input logic [2:0] opc, input logic [30:0] pos, input logic [7:0] mapq,
        input logic [11:0] flags, input logic [3:0] kind, input logic [27:0] len,
        input logic [3:0] code, input logic [7:0] qual);
        return {1'b0, qual, code, len, kind, flags, mapq, pos, opc};
    endfunction

    task automatic send_request(input logic [98:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= d[2:0];
        s_axis_tdata <= d[98:3];
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic release_bus();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        release_bus();
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [30:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_query(input logic [30:0] pos);
        send_request(pack_request(OP_QUERY, pos, 0, 0, 0, 0, 0, 0));
    endtask

    // One read: header, then a short CIGAR with bases under each op, and at times a query.
    task automatic send_read(input logic [30:0] lo, input int span);
        int nops, len;
        logic [3:0] kind;
        logic [11:0] flags;
        logic [3:0] cig_pick [0:8];
        cig_pick = '{CIG_M, CIG_M, CIG_EQ, CIG_X, CIG_I, CIG_D, CIG_N, CIG_S, CIG_H};
        flags = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom & 12'h8FB);
        send_request(pack_request(OP_HEADER, lo + 31'($urandom_range(span)),
                                  8'($urandom), flags, 0, 0, 0, 0));
        nops = $urandom_range(1, 4);
        for (int i = 0; i < nops; i++) begin
            kind = ($urandom_range(9) == 0) ? 4'($urandom) : cig_pick[$urandom_range(8)];
            len = $urandom_range(0, 6);
            send_request(pack_request(OP_CIGAR, 0, 0, 0, kind, 28'(len), 0, 0));
            for (int b = 0; b < len + $urandom_range(0, 1) - $urandom_range(0, 1); b++)
                send_request(pack_request(OP_BASE, 31'($urandom), 0, 0, 0, 0,
                    ($urandom_range(4) == 0) ? 4'($urandom) : 4'(1 << $urandom_range(3)),
                    8'($urandom)));
        end
        if ($urandom_range(2) == 0) send_query(lo + 31'($urandom_range(span)));
    endtask

    task automatic random_items(input int n, input logic [30:0] lo, input int span);
        int start;
        start = items_sent;
        while (items_sent - start < n) begin
            case ($urandom_range(19))
                0: send_request({1'b0, 31'($urandom), $urandom, $urandom, 3'($urandom)});
                1: send_request(pack_request(OP_CLEAR, lo + 31'($urandom_range(span)),
                                             0, 0, 0, 0, 0, 0));
                2, 3: send_query(($urandom_range(3) == 0) ? 31'($urandom) :
                                 lo + 31'($urandom_range(span)));
                default: send_read(lo, span);
            endcase
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        s_axis_tvalid = 0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default region, extremes and special cases.
        send_request(pack_request(OP_HEADER, 31'd10, 8'hFF, 12'h0, 0, 0, 0, 0));
        send_request(pack_request(OP_CIGAR, 0, 0, 0, CIG_M, 28'd3, 0, 0));
        send_request(pack_request(OP_BASE, 0, 0, 0, 0, 0, NT_A, 8'd0));
        send_request(pack_request(OP_BASE, 0, 0, 0, 0, 0, NT_T, 8'hFF));
        send_request(pack_request(OP_BASE, 0, 0, 0, 0, 0, 4'hF, 8'd45));
        send_request(pack_request(OP_BASE, 0, 0, 0, 0, 0, NT_C, 8'd30));
        send_request(pack_request(OP_CIGAR, 0, 0, 0, CIG_D, 28'hFFF_FFFF, 0, 0));
        send_request(pack_request(OP_CIGAR, 0, 0, 0, CIG_N, 28'hFFF_FFFF, 0, 0));
        send_request(pack_request(OP_CIGAR, 0, 0, 0, CIG_EQ, 28'd1, 0, 0));
        send_request(pack_request(OP_BASE, 0, 0, 0, 0, 0, NT_G, 8'd20));
        send_request(pack_request(OP_HEADER, 31'd4095, 0, 12'h004, 0, 0, 0, 0));
        send_request(pack_request(OP_CIGAR, 0, 0, 0, CIG_X, 28'd1, 0, 0));
        send_request(pack_request(OP_BASE, 0, 0, 0, 0, 0, NT_A, 8'd50));
        send_request(pack_request(OP_HEADER, 31'd4095, 0, 12'h8FB, 0, 0, 0, 0));
        send_request(pack_request(OP_CIGAR, 0, 0, 0, CIG_S, 28'd1, 0, 0));
        send_request(pack_request(OP_BASE, 0, 0, 0, 0, 0, NT_A, 8'd50));
        send_request(pack_request(OP_CIGAR, 0, 0, 0, CIG_X, 28'd1, 0, 0));
        send_request(pack_request(OP_BASE, 0, 0, 0, 0, 0, NT_A, 8'd95));
        send_query(31'd10);
        send_query(31'd11);
        send_query(31'd4095);
        send_query(31'h7FFF_FFFF);
        send_request(pack_request(OP_CLEAR, 31'd10, 0, 0, 0, 0, 0, 0));
        send_request({1'b0, 98'h3_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF});
        send_query(31'd10);
        drain_results();

        // Phase settings: region near the top, floors at extremes, idling.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  win_lo = 31'd0; end
                1: begin send_idle_pct = 85; stall_pct = 0;  win_lo = 31'h7FFF_FF00; end
                2: begin send_idle_pct = 0;  stall_pct = 85; win_lo = 31'd1000; end
                3: begin send_idle_pct = 10; stall_pct = 10; win_lo = 31'h2AAA_AAAA; end
                default: begin send_idle_pct = 0; stall_pct = 0; win_lo = 31'h5555_5555; end
            endcase
            write_register(REG_START, win_lo);
            write_register(REG_END, (ph == 1) ? 31'h7FFF_FFFF : win_lo + 31'd5000);
            write_register(REG_MAPQ, (ph == 2) ? 31'd255 : 31'($urandom_range(40)));
            write_register(REG_BASEQ, (ph == 4) ? 31'd255 : 31'($urandom_range(30)));
            random_items(150, win_lo, 60);
            drain_results();
        end

        drain_results();
        $display("Sent %0d requests and checked %0d query results", items_sent,
                 queries_seen);
        $display("over five region and quality settings with mixed idling.");
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire

// ===== aligned_read_pileup_counter_unit.f =====
sv/arpc_pkg.sv
sv/arpc_ram.sv
sv/aligned_read_pileup_counter_unit.sv
sim/pileup_checker.sv
sim/tb_top.sv
